// File: src/fpdl_pkg.sv
// shared constants and control types of the fixed point dense layer
package fpdl_pkg;

  localparam int MAX_INPUTS_DEF  = 256;
  localparam int MAX_OUTPUTS_DEF = 16;

  localparam int DATA_W       = 16;
  localparam int WADDR_W      = 12;
  localparam int WEIGHT_DEPTH = 4096;
  localparam int BIAS_AW      = 4;
  localparam int BIAS_DEPTH   = 16;
  localparam int ACC_W        = 40;
  localparam int PROD_W       = 32;
  localparam int LOGIT_W      = 17;
  localparam int OUT_IDX_W    = 4;
  localparam int FRAC_W       = 4;

  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 24;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  // item kinds carried in tuser
  localparam logic [S_TUSER_W-1:0] MODE_WEIGHT = 2'd0;
  localparam logic [S_TUSER_W-1:0] MODE_BIAS   = 2'd1;
  localparam logic [S_TUSER_W-1:0] MODE_ACT    = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRACTION_BITS = 8'd3;

  localparam logic [8:0] INPUT_COUNT_RST   = 9'd250;
  localparam logic [4:0] OUTPUT_COUNT_RST  = 5'd16;
  localparam logic       OUTPUT_MODE_RST   = 1'b0;
  localparam logic [3:0] FRACTION_BITS_RST = 4'd12;

  typedef struct packed {
    logic               wgt_we;
    logic               bias_we;
    logic               act_load;
    logic               mac_issue;
    logic               acc_rd;
    logic               arg_upd;
    logic               arg_first;
    logic               emit_relu;
    logic               emit_arg;
    logic               out_last;
    logic               acc_clr;
    logic [FRAC_W-1:0]  frac_bits;
    logic [WADDR_W-1:0] wgt_raddr;
  } fpdl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } fpdl_sts_t;

endpackage

// File: src/fixed_point_dense_layer.sv
// top level of the fixed point dense layer: controller and datapath
// weight or bias beat: written into its store as it is accepted
// activation beat: one accumulator update a cycle through one multiplier, then a drain of the mac pipe
// vector end: after the last activation, a read state and a write state per output (and a final
//   argmax beat in argmax mode), paced by the accumulator memory read and the output register
// reset: registers return to defaults, accumulators read as zero through per-entry
//   valid bits, weight and bias stores hold whatever they held
module fixed_point_dense_layer #(
  parameter int MAX_INPUTS  = fpdl_pkg::MAX_INPUTS_DEF,
  parameter int MAX_OUTPUTS = fpdl_pkg::MAX_OUTPUTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // address [11:0], value [27:12]
  input  logic [fpdl_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // mode [1:0]
  input  logic [fpdl_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_index [3:0], out_value [20:4]
  output logic [fpdl_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fpdl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fpdl_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import fpdl_pkg::*;

  localparam int OIW = $clog2(MAX_OUTPUTS);

  fpdl_cmd_t      cmd;
  fpdl_sts_t      sts;
  logic [OIW-1:0] acc_idx;

  fpdl_ctrl #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS),
    .OIW         (OIW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .acc_idx_o     (acc_idx)
  );

  fpdl_datapath #(
    .MAX_OUTPUTS (MAX_OUTPUTS),
    .OIW         (OIW)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .cmd_i         (cmd),
    .acc_idx_i     (acc_idx),
    .sts_o         (sts),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: src/fpdl_ctrl.sv
// controller: configuration registers, activation counter and sequencing fsm
module fpdl_ctrl #(
  parameter int MAX_INPUTS  = fpdl_pkg::MAX_INPUTS_DEF,
  parameter int MAX_OUTPUTS = fpdl_pkg::MAX_OUTPUTS_DEF,
  parameter int OIW         = $clog2(MAX_OUTPUTS)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [fpdl_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [fpdl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fpdl_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  fpdl_pkg::fpdl_sts_t        sts_i,
  output fpdl_pkg::fpdl_cmd_t        cmd_o,
  output logic [OIW-1:0]             acc_idx_o
);
  import fpdl_pkg::*;

  localparam int CNTW = $clog2(MAX_INPUTS + 1);
  localparam int OW   = $clog2(MAX_OUTPUTS + 1);
  localparam int PW   = CNTW + OW;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MAC    = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_EM_RD  = 3'd3;
  localparam logic [2:0] ST_EM_WR  = 3'd4;
  localparam logic [2:0] ST_EM_ARG = 3'd5;

  logic [8:0]         in_cnt_q;
  logic [4:0]         out_cnt_q;
  logic               out_mode_q;
  logic [3:0]         frac_q;
  logic [2:0]         state_q, state_d;
  logic [OIW-1:0]     o_q, o_d;
  logic [CNTW-1:0]    cnt_q, cnt_d;
  logic [WADDR_W-1:0] base_q, base_d;
  logic [CNTW-1:0]    n_in;
  logic [OW-1:0]      n_out;
  logic [PW-1:0]      base_full;
  logic               o_last;
  logic               vec_done;
  logic               accept;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q   <= INPUT_COUNT_RST;
      out_cnt_q  <= OUTPUT_COUNT_RST;
      out_mode_q <= OUTPUT_MODE_RST;
      frac_q     <= FRACTION_BITS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_INPUT_COUNT:   in_cnt_q   <= cfg_data_i[8:0];
        CFG_OUTPUT_COUNT:  out_cnt_q  <= cfg_data_i[4:0];
        CFG_OUTPUT_MODE:   out_mode_q <= cfg_data_i[0];
        CFG_FRACTION_BITS: frac_q     <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // zero counts as one, large values saturate
  assign n_in  = (in_cnt_q == '0) ? CNTW'(1) :
                 (32'(in_cnt_q) > MAX_INPUTS) ? CNTW'(MAX_INPUTS) : CNTW'(in_cnt_q);
  assign n_out = (out_cnt_q == '0) ? OW'(1) :
                 (32'(out_cnt_q) > MAX_OUTPUTS) ? OW'(MAX_OUTPUTS) : OW'(out_cnt_q);

  assign base_full = PW'(cnt_q) * PW'(n_out);
  assign o_last    = (OW'(o_q) + OW'(1)) == n_out;
  assign vec_done  = !((CNTW+1)'(cnt_q) + (CNTW+1)'(1) < (CNTW+1)'(n_in));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign acc_idx_o     = o_q;

  always_comb begin
    state_d = state_q;
    o_d     = o_q;
    cnt_d   = cnt_q;
    base_d  = base_q;
    cmd_o   = '0;
    cmd_o.frac_bits = frac_q;
    cmd_o.wgt_raddr = base_q + WADDR_W'(o_q);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            MODE_WEIGHT: cmd_o.wgt_we = 1'b1;
            MODE_BIAS:   cmd_o.bias_we = 1'b1;
            MODE_ACT: begin
              cmd_o.act_load = 1'b1;
              base_d  = WADDR_W'(base_full);
              o_d     = '0;
              state_d = ST_MAC;
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        cmd_o.mac_issue = 1'b1;
        if (o_last) begin
          state_d = ST_DRAIN;
        end else begin
          o_d = o_q + OIW'(1);
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          o_d = '0;
          if (vec_done) begin
            cnt_d   = '0;
            state_d = ST_EM_RD;
          end else begin
            cnt_d   = cnt_q + CNTW'(1);
            state_d = ST_IDLE;
          end
        end
      end
      ST_EM_RD: begin
        cmd_o.acc_rd = 1'b1;
        state_d      = ST_EM_WR;
      end
      ST_EM_WR: begin
        if (out_mode_q) begin
          cmd_o.arg_upd   = 1'b1;
          cmd_o.arg_first = (o_q == '0);
          if (o_last) begin
            state_d = ST_EM_ARG;
          end else begin
            o_d     = o_q + OIW'(1);
            state_d = ST_EM_RD;
          end
        end else if (sts_i.out_free) begin
          cmd_o.emit_relu = 1'b1;
          cmd_o.out_last  = o_last;
          if (o_last) begin
            cmd_o.acc_clr = 1'b1;
            state_d       = ST_IDLE;
          end else begin
            o_d     = o_q + OIW'(1);
            state_d = ST_EM_RD;
          end
        end
      end
      ST_EM_ARG: begin
        if (sts_i.out_free) begin
          cmd_o.emit_arg = 1'b1;
          cmd_o.out_last = 1'b1;
          cmd_o.acc_clr  = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      o_q     <= '0;
      cnt_q   <= '0;
      base_q  <= '0;
    end else begin
      state_q <= state_d;
      o_q     <= o_d;
      cnt_q   <= cnt_d;
      base_q  <= base_d;
    end
  end

endmodule

// File: src/fpdl_datapath.sv
// datapath: weight and accumulator memories, bias registers, mac pipe, scaling and output beat
module fpdl_datapath #(
  parameter int MAX_OUTPUTS = fpdl_pkg::MAX_OUTPUTS_DEF,
  parameter int OIW         = $clog2(MAX_OUTPUTS)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [fpdl_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  fpdl_pkg::fpdl_cmd_t            cmd_i,
  input  logic [OIW-1:0]                 acc_idx_i,
  output fpdl_pkg::fpdl_sts_t            sts_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [fpdl_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast
);
  import fpdl_pkg::*;

  logic [WADDR_W-1:0]       in_addr;
  logic signed [DATA_W-1:0] in_value;

  logic signed [DATA_W-1:0] wgt_mem [WEIGHT_DEPTH];
  logic signed [DATA_W-1:0] bias_q  [BIAS_DEPTH];
  logic [ACC_W-1:0]         acc_mem [MAX_OUTPUTS];
  logic [MAX_OUTPUTS-1:0]   acc_vld_q;

  logic signed [DATA_W-1:0] act_q;
  logic signed [DATA_W-1:0] wgt_rd_q;
  logic [ACC_W-1:0]         acc_rd_q;
  logic                     acc_rv_q;
  logic signed [DATA_W-1:0] bias_rd_q;
  logic [ACC_W-1:0]         acc_eff;
  logic                     acc_rd_en;

  logic                     s1_v_q, s2_v_q;
  logic [OIW-1:0]           s1_idx_q, s2_idx_q;
  logic [ACC_W-1:0]         s2_acc_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]         acc_sum;

  logic signed [ACC_W-1:0]   shifted;
  logic signed [LOGIT_W-1:0] logit;
  logic [DATA_W-1:0]         relu;
  logic signed [LOGIT_W-1:0] best_q;
  logic [OIW-1:0]            best_idx_q;

  logic                     out_v_q;
  logic [M_TDATA_W-1:0]     out_data_q;
  logic                     out_last_q;

  assign in_addr  = s_axis_tdata[WADDR_W-1:0];
  assign in_value = s_axis_tdata[WADDR_W +: DATA_W];
  assign acc_rd_en = cmd_i.mac_issue || cmd_i.acc_rd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wgt_we) begin
      wgt_mem[in_addr] <= in_value;
    end
    if (cmd_i.mac_issue) begin
      wgt_rd_q <= wgt_mem[cmd_i.wgt_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bias_we) begin
      bias_q[in_addr[BIAS_AW-1:0]] <= in_value;
    end
    if (cmd_i.acc_rd) begin
      bias_rd_q <= bias_q[BIAS_AW'(acc_idx_i)];
    end
    if (cmd_i.act_load) begin
      act_q <= in_value;
    end
  end

  // accumulator memory, one write and one read port
  always_ff @(posedge clk_i) begin
    if (s2_v_q) begin
      acc_mem[s2_idx_q] <= acc_sum;
    end
    if (acc_rd_en) begin
      acc_rd_q <= acc_mem[acc_idx_i];
    end
  end

  // per-entry valid bits stand in for clearing the accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= '0;
      acc_rv_q  <= 1'b0;
    end else begin
      if (cmd_i.acc_clr) begin
        acc_vld_q <= '0;
      end else if (s2_v_q) begin
        acc_vld_q[s2_idx_q] <= 1'b1;
      end
      if (acc_rd_en) begin
        acc_rv_q <= acc_vld_q[acc_idx_i];
      end
    end
  end

  assign acc_eff = acc_rv_q ? acc_rd_q : '0;

  // mac pipe: read, multiply, accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.mac_issue;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= acc_idx_i;
    s2_idx_q <= s1_idx_q;
    s2_acc_q <= acc_eff;
    prod_q   <= act_q * wgt_rd_q;
  end

  assign acc_sum = s2_acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  // scaling, bias and relu
  assign shifted = $signed(acc_eff) >>> cmd_i.frac_bits;
  assign logit   = {shifted[DATA_W-1], shifted[DATA_W-1:0]}
                 + {bias_rd_q[DATA_W-1], bias_rd_q};
  assign relu    = logit[DATA_W-1] ? '0 : logit[DATA_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.arg_upd && (cmd_i.arg_first || (logit > best_q))) begin
      best_q     <= logit;
      best_idx_q <= acc_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.emit_relu || cmd_i.emit_arg) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_relu) begin
      out_data_q <= M_TDATA_W'({1'b0, relu, OUT_IDX_W'(acc_idx_i)});
      out_last_q <= cmd_i.out_last;
    end else if (cmd_i.emit_arg) begin
      out_data_q <= M_TDATA_W'({best_q, OUT_IDX_W'(best_idx_q)});
      out_last_q <= cmd_i.out_last;
    end
  end

  assign m_axis_tvalid   = out_v_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tlast    = out_last_q;
  assign sts_o.pipe_busy = s1_v_q || s2_v_q;
  assign sts_o.out_free  = !out_v_q || m_axis_tready;

endmodule
